### hdl/wuau_pkg.sv
// ----------------------------------------------------------------------------
// Wide unsigned arithmetic unit package
// Operation and status codes, controller states and the command and status
// records exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package wuau_pkg;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_DBZ = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SMEAR,
    S_ITER,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic smear;
    logic iter;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  b_zero;
  } dp_status_t;

endpackage

### hdl/wide_unsigned_arith_unit.sv
// From the accepting edge, add passes through setup and result capture before
// the result strobe; subtract and divide by zero also pass through the mask
// builder, and multiply and divide through bit iteration, one operand bit per
// cycle in the shared shift unit. One transaction at a time;
// start is taken again in the strobe cycle. The receiver cannot stall.
// Reset is synchronous and active low; it clears the controller and strobe.
// ----------------------------------------------------------------------------
// Wide unsigned arithmetic unit
// Unsigned add, subtract, multiply and divide over WIDTH-bit operands.
// ----------------------------------------------------------------------------
module wide_unsigned_arith_unit
  import wuau_pkg::*;
#(
  parameter int WIDTH = 96
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_a_low,
  input  logic [31:0] in_a_high,
  input  logic [63:0] in_b_low,
  input  logic [31:0] in_b_high,
  output logic        out_strobe,
  output logic [63:0] out_result_low,
  output logic [31:0] out_result_high,
  output logic [63:0] out_rem_low,
  output logic [31:0] out_rem_high,
  output logic [1:0]  out_status
);

  dp_cmd_t    cmd;
  dp_status_t dp_stat;

  wuau_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .dp_stat    (dp_stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  wuau_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk             (clk),
    .in_mode         (in_mode),
    .in_a_low        (in_a_low),
    .in_a_high       (in_a_high),
    .in_b_low        (in_b_low),
    .in_b_high       (in_b_high),
    .cmd             (cmd),
    .stat            (dp_stat),
    .out_result_low  (out_result_low),
    .out_result_high (out_result_high),
    .out_rem_low     (out_rem_low),
    .out_rem_high    (out_rem_high),
    .out_status      (out_status)
  );

endmodule

### hdl/wuau_ctrl.sv
// ----------------------------------------------------------------------------
// Wide unsigned arithmetic unit controller
// Sequences one transaction through setup, mask building or bit iteration as
// the mode needs, and result capture, and issues the result strobe.
// ----------------------------------------------------------------------------
module wuau_ctrl
  import wuau_pkg::*;
#(
  parameter int WIDTH = 96
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t dp_stat,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       out_strobe
);

  localparam int CW          = $clog2(WIDTH + 1);
  localparam int SMEAR_STEPS = $clog2(WIDTH);

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           strobe_r, strobe_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        priority if (dp_stat.mode == MODE_ADD) begin
          state_nxt = S_FIN;
        end else if (dp_stat.mode == MODE_SUB ||
                     (dp_stat.mode == MODE_DIV && dp_stat.b_zero)) begin
          state_nxt = S_SMEAR;
          cnt_nxt   = CW'(SMEAR_STEPS - 1);
        end else begin
          state_nxt = S_ITER;
          cnt_nxt   = CW'(WIDTH - 1);
        end
      end
      S_SMEAR, S_ITER: begin
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    busy       = 1'b1;
    strobe_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_SETUP: begin
      end
      S_SMEAR: begin
        cmd.smear = 1'b1;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        strobe_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_strobe = strobe_r;

endmodule

### hdl/wuau_datapath.sv
// ----------------------------------------------------------------------------
// Wide unsigned arithmetic unit datapath
// Operand registers, significant-bit mask builder, shift-and-add multiply and
// restoring divide step, and the result registers.
// ----------------------------------------------------------------------------
module wuau_datapath
  import wuau_pkg::*;
#(
  parameter int WIDTH = 96
) (
  input  logic        clk,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_a_low,
  input  logic [31:0] in_a_high,
  input  logic [63:0] in_b_low,
  input  logic [31:0] in_b_high,
  input  dp_cmd_t     cmd,
  output dp_status_t  stat,
  output logic [63:0] out_result_low,
  output logic [31:0] out_result_high,
  output logic [63:0] out_rem_low,
  output logic [31:0] out_rem_high,
  output logic [1:0]  out_status
);

  localparam int CW = $clog2(WIDTH + 1);

  mode_t            mode_r;
  logic [WIDTH-1:0] a_r, b_r, acc_r, rem_r, mask_r;
  logic [CW-1:0]    sa_r;
  logic             shout_r, ovf_r;
  logic [127:0]     res_ext_r, rem_ext_r;
  status_t          status_r;

  logic [127:0]     a_in_ext, b_in_ext;
  logic [WIDTH:0]   mul_sum, div_sh, div_diff, add_sum;
  logic             div_ge;
  logic [WIDTH-1:0] res_fin, rem_fin;
  status_t          status_fin;

  assign a_in_ext = 128'({in_a_high, in_a_low});
  assign b_in_ext = 128'({in_b_high, in_b_low});

  assign mul_sum  = {1'b0, acc_r} + {1'b0, rem_r};
  assign div_sh   = {rem_r, a_r[WIDTH-1]};
  assign div_diff = div_sh - {1'b0, b_r};
  assign div_ge   = (div_sh >= {1'b0, b_r});
  assign add_sum  = {1'b0, a_r} + {1'b0, b_r};

  assign stat.mode   = mode_r;
  assign stat.b_zero = (b_r == '0);

  always_comb begin
    res_fin    = '0;
    rem_fin    = '0;
    status_fin = ST_OK;
    unique case (mode_r)
      MODE_ADD: begin
        if (add_sum[WIDTH]) begin
          status_fin = ST_OVF;
        end else begin
          res_fin = add_sum[WIDTH-1:0];
        end
      end
      MODE_SUB: begin
        res_fin = (a_r - b_r) & mask_r;
      end
      MODE_MUL: begin
        if (ovf_r) begin
          status_fin = ST_OVF;
        end else begin
          res_fin = acc_r;
        end
      end
      MODE_DIV: begin
        if (b_r == '0) begin
          res_fin    = mask_r;
          rem_fin    = a_r;
          status_fin = ST_DBZ;
        end else begin
          res_fin = acc_r;
          rem_fin = rem_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= mode_t'(in_mode);
      a_r     <= a_in_ext[WIDTH-1:0];
      b_r     <= b_in_ext[WIDTH-1:0];
      mask_r  <= a_in_ext[WIDTH-1:0];
      sa_r    <= CW'(1);
      acc_r   <= '0;
      shout_r <= 1'b0;
      ovf_r   <= 1'b0;
      if (mode_t'(in_mode) == MODE_MUL) begin
        rem_r <= b_in_ext[WIDTH-1:0];
      end else begin
        rem_r <= '0;
      end
    end else if (cmd.smear) begin
      mask_r <= mask_r | (mask_r >> sa_r);
      sa_r   <= sa_r << 1;
    end else if (cmd.iter) begin
      if (mode_r == MODE_MUL) begin
        a_r     <= a_r >> 1;
        rem_r   <= rem_r << 1;
        shout_r <= shout_r | rem_r[WIDTH-1];
        if (a_r[0]) begin
          acc_r <= mul_sum[WIDTH-1:0];
          ovf_r <= ovf_r | mul_sum[WIDTH] | shout_r;
        end
      end else begin
        a_r   <= a_r << 1;
        acc_r <= {acc_r[WIDTH-2:0], div_ge};
        rem_r <= div_ge ? div_diff[WIDTH-1:0] : div_sh[WIDTH-1:0];
      end
    end else if (cmd.finish) begin
      res_ext_r <= 128'(res_fin);
      rem_ext_r <= 128'(rem_fin);
      status_r  <= status_fin;
    end
  end

  assign out_result_low  = res_ext_r[63:0];
  assign out_result_high = res_ext_r[95:64];
  assign out_rem_low     = rem_ext_r[63:0];
  assign out_rem_high    = rem_ext_r[95:64];
  assign out_status      = status_r;

endmodule

### hdl/wuau_checker.sv
// ----------------------------------------------------------------------------
// Wide unsigned arithmetic unit checker
// Port-level assertions on the command handshake and the result strobe.
// ----------------------------------------------------------------------------
module wuau_checker
  import wuau_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [63:0] out_result_low,
  input logic [31:0] out_result_high,
  input logic [1:0]  out_status
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("Result strobe lasted more than one cycle.");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted transaction did not raise busy.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_status == ST_OK || out_status == ST_OVF ||
                    out_status == ST_DBZ))
    else $error("Result carries an undefined status code.");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_OVF) |->
      (out_result_low == 64'd0 && out_result_high == 32'd0))
    else $error("Overflow result is not zero.");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_strobe)
    else $error("Transaction ended without a result strobe.");

endmodule

bind wide_unsigned_arith_unit wuau_checker u_wuau_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wide unsigned arithmetic unit testbench
// Drives add, subtract, multiply and divide transactions through the command
// handshake. A directed table covers the operand extremes and the special
// cases, and a long random run follows. Each result is compared field by field
// in issue order with typed row values or an independent arithmetic predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import wuau_pkg::*;

  localparam int OPW        = 96;
  localparam int RAND_ITEMS = 850;
  localparam int CYCLE_CAP  = 400000;

  localparam logic [OPW-1:0] ZERO = '0;
  localparam logic [OPW-1:0] ONES = {OPW{1'b1}};
  localparam logic [OPW-1:0] ONE  = 96'd1;

  typedef struct {
    logic [OPW-1:0] quo;
    logic [OPW-1:0] rem;
    status_t        st;
  } arith_res_t;

  typedef struct {
    mode_t          mode;
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;
    bit             typed;
    arith_res_t     res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = '0;
  logic [63:0] in_a_low = '0;
  logic [31:0] in_a_high = '0;
  logic [63:0] in_b_low = '0;
  logic [31:0] in_b_high = '0;
  logic        out_strobe;
  logic [63:0] out_result_low;
  logic [31:0] out_result_high;
  logic [63:0] out_rem_low;
  logic [31:0] out_rem_high;
  logic [1:0]  out_status;

  arith_res_t pending_results[$];
  dir_row_t   dir_tab[$];
  int         err_count = 0;
  int         cycle_count = 0;

  wide_unsigned_arith_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_a_low        (in_a_low),
    .in_a_high       (in_a_high),
    .in_b_low        (in_b_low),
    .in_b_high       (in_b_high),
    .out_strobe      (out_strobe),
    .out_result_low  (out_result_low),
    .out_result_high (out_result_high),
    .out_rem_low     (out_rem_low),
    .out_rem_high    (out_rem_high),
    .out_status      (out_status)
  );

  always #6 clk = ~clk;

  function automatic logic [OPW-1:0] len_mask(int n);
    if (n >= OPW) begin
      return ONES;
    end
    return (ONE << n) - ONE;
  endfunction

  function automatic arith_res_t predict_arith(mode_t m, logic [OPW-1:0] a,
                                               logic [OPW-1:0] b);
    arith_res_t       res;
    logic [OPW:0]     sum;
    logic [2*OPW-1:0] prod;
    int               alen;
    res.quo = ZERO;
    res.rem = ZERO;
    res.st  = ST_OK;
    alen    = 0;
    for (int i = 0; i < OPW; i++) begin
      if (a[i]) alen = i + 1;
    end
    case (m)
      MODE_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        if (sum[OPW]) res.st = ST_OVF;
        else res.quo = sum[OPW-1:0];
      end
      MODE_SUB: begin
        res.quo = (a - b) & len_mask(alen);
      end
      MODE_MUL: begin
        prod = {ZERO, a} * {ZERO, b};
        if (prod[2*OPW-1:OPW] != ZERO) res.st = ST_OVF;
        else res.quo = prod[OPW-1:0];
      end
      default: begin
        if (b == ZERO) begin
          res.quo = len_mask(alen);
          res.rem = a;
          res.st  = ST_DBZ;
        end else begin
          res.quo = a / b;
          res.rem = a % b;
        end
      end
    endcase
    return res;
  endfunction

  function automatic logic [OPW-1:0] rand_operand(int max_len);
    logic [OPW-1:0] v;
    int             len;
    int             kind;
    v    = {$urandom, $urandom, $urandom};
    kind = $urandom_range(0, 9);
    len  = $urandom_range(1, max_len);
    case (kind)
      0: v = ZERO;
      1: v = ONES;
      2: v = v;
      3: v = ONE << $urandom_range(0, max_len - 1);
      default: v = (v & len_mask(len)) | (ONE << (len - 1));
    endcase
    return v;
  endfunction

  task automatic send_item(input mode_t m, input logic [OPW-1:0] a,
                           input logic [OPW-1:0] b, input bit typed,
                           input arith_res_t typed_res);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_mode   <= m;
    in_a_low  <= a[63:0];
    in_a_high <= a[95:64];
    in_b_low  <= b[63:0];
    in_b_high <= b[95:64];
    do @(posedge clk); while (busy);
    if (typed) pending_results.push_back(typed_res);
    else pending_results.push_back(predict_arith(m, a, b));
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    arith_res_t exp_res;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation waiting");
        err_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_result_low !== exp_res.quo[63:0]) begin
          $error("out_result_low: expected %h, got %h", exp_res.quo[63:0], out_result_low);
          err_count++;
        end
        if (out_result_high !== exp_res.quo[95:64]) begin
          $error("out_result_high: expected %h, got %h", exp_res.quo[95:64],
                 out_result_high);
          err_count++;
        end
        if (out_rem_low !== exp_res.rem[63:0]) begin
          $error("out_rem_low: expected %h, got %h", exp_res.rem[63:0], out_rem_low);
          err_count++;
        end
        if (out_rem_high !== exp_res.rem[95:64]) begin
          $error("out_rem_high: expected %h, got %h", exp_res.rem[95:64], out_rem_high);
          err_count++;
        end
        if (out_status !== exp_res.st) begin
          $error("out_status: expected %0d, got %0d", exp_res.st, out_status);
          err_count++;
        end
      end
    end
  end

  initial begin
    arith_res_t     none;
    mode_t          m;
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;
    int             la;
    none = arith_res_t'{ZERO, ZERO, ST_OK};

    dir_tab.push_back(dir_row_t'{MODE_ADD, ONES, ONES, 1'b1, arith_res_t'{ZERO, ZERO, ST_OVF}});
    dir_tab.push_back(dir_row_t'{MODE_ADD, ZERO, ZERO, 1'b1, arith_res_t'{ZERO, ZERO, ST_OK}});
    dir_tab.push_back(dir_row_t'{MODE_ADD, ONES, ZERO, 1'b1, arith_res_t'{ONES, ZERO, ST_OK}});
    dir_tab.push_back(dir_row_t'{MODE_ADD, ONE << 95, ONE << 95, 1'b0, none});
    dir_tab.push_back(dir_row_t'{MODE_ADD, len_mask(64), ONE, 1'b0, none});
    dir_tab.push_back(dir_row_t'{MODE_ADD, ONES - ONE, ONE, 1'b0, none});
    dir_tab.push_back(dir_row_t'{MODE_SUB, ZERO, ONES, 1'b1, arith_res_t'{ZERO, ZERO, ST_OK}});
    dir_tab.push_back(dir_row_t'{MODE_SUB, ONES, ZERO, 1'b1, arith_res_t'{ONES, ZERO, ST_OK}});
    dir_tab.push_back(dir_row_t'{MODE_SUB, ONE, 96'd2, 1'b0, none});
    dir_tab.push_back(dir_row_t'{MODE_SUB, 96'd5, 96'd7, 1'b0, none});
    dir_tab.push_back(dir_row_t'{MODE_SUB, ONE << 64, ONES, 1'b0, none});
    dir_tab.push_back(dir_row_t'{MODE_SUB, ONES, ONES, 1'b0, none});
    dir_tab.push_back(dir_row_t'{MODE_MUL, ONES, ONES, 1'b1, arith_res_t'{ZERO, ZERO, ST_OVF}});
    dir_tab.push_back(dir_row_t'{MODE_MUL, ZERO, ONES, 1'b1, arith_res_t'{ZERO, ZERO, ST_OK}});
    dir_tab.push_back(dir_row_t'{MODE_MUL, ONES, ONE, 1'b1, arith_res_t'{ONES, ZERO, ST_OK}});
    dir_tab.push_back(dir_row_t'{MODE_MUL, ONE << 95, 96'd2, 1'b0, none});
    dir_tab.push_back(dir_row_t'{MODE_MUL, ONE << 48, ONE << 47, 1'b0, none});
    dir_tab.push_back(dir_row_t'{MODE_MUL, len_mask(48), len_mask(48), 1'b0, none});
    dir_tab.push_back(dir_row_t'{MODE_DIV, ZERO, ZERO, 1'b1, arith_res_t'{ZERO, ZERO, ST_DBZ}});
    dir_tab.push_back(dir_row_t'{MODE_DIV, ONES, ZERO, 1'b1, arith_res_t'{ONES, ONES, ST_DBZ}});
    dir_tab.push_back(dir_row_t'{MODE_DIV, ONES, ONES, 1'b1, arith_res_t'{ONE, ZERO, ST_OK}});
    dir_tab.push_back(dir_row_t'{MODE_DIV, ONES, ONE, 1'b1, arith_res_t'{ONES, ZERO, ST_OK}});
    dir_tab.push_back(dir_row_t'{MODE_DIV, 96'h1234, ZERO, 1'b0, none});
    dir_tab.push_back(dir_row_t'{MODE_DIV, 96'd7, ONES, 1'b0, none});
    dir_tab.push_back(dir_row_t'{MODE_DIV, ONES, 96'd10, 1'b0, none});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].mode, dir_tab[i].a, dir_tab[i].b, dir_tab[i].typed,
                dir_tab[i].res);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      m = mode_t'($urandom_range(0, 3));
      case (m)
        MODE_MUL: begin
          la = $urandom_range(1, 95);
          a  = rand_operand(la);
          b  = rand_operand(97 - la);
        end
        MODE_DIV: begin
          a = rand_operand(OPW);
          b = rand_operand($urandom_range(1, OPW));
        end
        default: begin
          a = rand_operand(OPW);
          b = rand_operand(OPW);
        end
      endcase
      if (n == RAND_ITEMS / 2) begin
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      send_item(m, a, b, 1'b0, none);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (OPW + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
